// ===== design/bsp_point_contents_walk_assert.svh =====
`ifndef BSP_POINT_CONTENTS_WALK_ASSERT_SVH
`define BSP_POINT_CONTENTS_WALK_ASSERT_SVH

// Condition must hold in the same cycle as the trigger. Expects clk and rst in scope.
`define BSPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger. Expects clk and rst in scope.
`define BSPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bspw_pkg.sv =====
package bspw_pkg;

  // Default table sizes.
  localparam int MAX_NODES_DEF  = 4096;
  localparam int MAX_PLANES_DEF = 4096;

  // Field widths of the item channels and configuration port.
  localparam int OP_W        = 2;
  localparam int IDX_W       = 12;
  localparam int CHILD_W     = 16;
  localparam int PLANE_REF_W = 12;
  localparam int KIND_W      = 3;
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;

  // Packed memory words: node is {plane, front, back}; plane is {kind, nx, ny, nz, dist}.
  localparam int NODE_DATA_W  = PLANE_REF_W + 2 * CHILD_W;
  localparam int PLANE_DATA_W = KIND_W + 4 * COORD_W;

  // Dot product: 32x32 products, three of them plus the shifted distance.
  localparam int PROD_W = 2 * COORD_W;
  localparam int ACC_W  = PROD_W + 3;

  // Plane kinds below this are axial.
  localparam logic [KIND_W-1:0] AXIAL_KINDS = KIND_W'(3);

  // Axis selectors, shared by the axial kind code and the dot product lane counter.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Contents code returned on a bad walk.
  localparam logic signed [CHILD_W-1:0] SOLID_CODE = -CHILD_W'(2);

  // Configuration reset values.
  localparam logic [CFG_W-1:0] FIRST_NODE_RST = '0;
  localparam logic [CFG_W-1:0] LAST_NODE_RST  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_NODE_WR  = 2'd0,
    OP_PLANE_WR = 2'd1,
    OP_QUERY    = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_NODE = 1'b0,
    CFG_LAST_NODE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_CHECK,
    WS_PLANE,
    WS_DIST,
    WS_WAIT,
    WS_DONE
  } walk_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_MUL,
    DS_SUM
  } dist_state_t;

  typedef struct packed {
    logic done;
    logic neg;
  } dist_status_t;

endpackage

// ===== design/bspw_in_if.sv =====
interface bspw_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [bspw_pkg::OP_W-1:0]        operation;
  logic        [bspw_pkg::IDX_W-1:0]       index;
  logic signed [bspw_pkg::CHILD_W-1:0]     child_front;
  logic signed [bspw_pkg::CHILD_W-1:0]     child_back;
  logic        [bspw_pkg::PLANE_REF_W-1:0] plane_ref;
  logic        [bspw_pkg::KIND_W-1:0]      plane_kind;
  logic signed [bspw_pkg::COORD_W-1:0]     coord_x;
  logic signed [bspw_pkg::COORD_W-1:0]     coord_y;
  logic signed [bspw_pkg::COORD_W-1:0]     coord_z;
  logic signed [bspw_pkg::COORD_W-1:0]     plane_offset;

  modport source (
    output valid, operation, index, child_front, child_back, plane_ref, plane_kind,
           coord_x, coord_y, coord_z, plane_offset,
    input  ready
  );

  modport sink (
    input  valid, operation, index, child_front, child_back, plane_ref, plane_kind,
           coord_x, coord_y, coord_z, plane_offset,
    output ready
  );
endinterface

// ===== design/bspw_out_if.sv =====
interface bspw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bspw_pkg::CHILD_W-1:0] contents;
  logic                                 bad_node;

  modport source (
    output valid, contents, bad_node,
    input  ready
  );

  modport sink (
    input  valid, contents, bad_node,
    output ready
  );
endinterface

// ===== design/bspw_ram.sv =====
module bspw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bspw_dist.sv =====
module bspw_dist (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic        [bspw_pkg::KIND_W-1:0]  kind,
  input  logic signed [bspw_pkg::COORD_W-1:0] norm_x,
  input  logic signed [bspw_pkg::COORD_W-1:0] norm_y,
  input  logic signed [bspw_pkg::COORD_W-1:0] norm_z,
  input  logic signed [bspw_pkg::COORD_W-1:0] offset,
  input  logic signed [bspw_pkg::COORD_W-1:0] pt_x,
  input  logic signed [bspw_pkg::COORD_W-1:0] pt_y,
  input  logic signed [bspw_pkg::COORD_W-1:0] pt_z,
  output bspw_pkg::dist_status_t               status
);

  bspw_pkg::dist_state_t state, state_next;

  logic        [1:0]                     lane;
  logic signed [bspw_pkg::COORD_W-1:0]  nx, ny, nz;
  logic signed [bspw_pkg::PROD_W-1:0]   prod;
  logic signed [bspw_pkg::ACC_W-1:0]    acc;
  logic                                  done;
  logic                                  neg;
  logic                                  is_axial;
  logic                                  ld_axial, ld_general, mul_en, acc_en, fin;
  logic signed [bspw_pkg::COORD_W-1:0]  axial_pt, mul_n, mul_p;
  logic signed [bspw_pkg::COORD_W:0]    axial_diff;
  logic signed [bspw_pkg::ACC_W-1:0]    acc_init, acc_sum;

  // Axial planes: one coordinate minus the distance, exact in 33 bits.
  always_comb begin
    case (kind[1:0])
      bspw_pkg::AXIS_X: axial_pt = pt_x;
      bspw_pkg::AXIS_Y: axial_pt = pt_y;
      bspw_pkg::AXIS_Z: axial_pt = pt_z;
      default:          axial_pt = pt_x;
    endcase
  end

  assign is_axial   = kind < bspw_pkg::AXIAL_KINDS;
  assign axial_diff = (bspw_pkg::COORD_W + 1)'(axial_pt) - (bspw_pkg::COORD_W + 1)'(offset);

  // General planes: the accumulator starts at -dist scaled to 32.32.
  assign acc_init = -(bspw_pkg::ACC_W'(offset) <<< bspw_pkg::FRAC_W);
  assign acc_sum  = acc + bspw_pkg::ACC_W'(prod);

  // Multiplier operand select, one axis per cycle.
  always_comb begin
    case (lane)
      bspw_pkg::AXIS_X: begin
        mul_n = nx;
        mul_p = pt_x;
      end
      bspw_pkg::AXIS_Y: begin
        mul_n = ny;
        mul_p = pt_y;
      end
      default: begin
        mul_n = nz;
        mul_p = pt_z;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bspw_pkg::DS_IDLE: begin
        if (start && !is_axial) begin
          state_next = bspw_pkg::DS_MUL;
        end
      end
      bspw_pkg::DS_MUL: begin
        if (lane == bspw_pkg::AXIS_Z) begin
          state_next = bspw_pkg::DS_SUM;
        end
      end
      bspw_pkg::DS_SUM: state_next = bspw_pkg::DS_IDLE;
      default:          state_next = bspw_pkg::DS_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    ld_axial   = (state == bspw_pkg::DS_IDLE) && start && is_axial;
    ld_general = (state == bspw_pkg::DS_IDLE) && start && !is_axial;
    mul_en     = (state == bspw_pkg::DS_MUL);
    acc_en     = (state == bspw_pkg::DS_MUL) && (lane != bspw_pkg::AXIS_X);
    fin        = (state == bspw_pkg::DS_SUM);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bspw_pkg::DS_IDLE;
      lane  <= bspw_pkg::AXIS_X;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ld_axial || fin;
      if (ld_general) begin
        lane <= bspw_pkg::AXIS_X;
      end else if (mul_en) begin
        lane <= lane + 2'd1;
      end
    end
  end

  // Datapath: multiplier register, accumulator and sign result.
  always_ff @(posedge clk) begin
    if (ld_general) begin
      nx <= norm_x;
      ny <= norm_y;
      nz <= norm_z;
    end
    if (mul_en) begin
      prod <= mul_n * mul_p;
    end
    if (ld_general) begin
      acc <= acc_init;
    end else if (acc_en) begin
      acc <= acc_sum;
    end
    if (ld_axial) begin
      neg <= axial_diff[bspw_pkg::COORD_W];
    end else if (fin) begin
      neg <= acc_sum[bspw_pkg::ACC_W-1];
    end
  end

  assign status = '{done: done, neg: neg};

endmodule

// ===== design/bspw_walk_ctl.sv =====
`include "bsp_point_contents_walk_assert.svh"

module bspw_walk_ctl #(
  parameter int MAX_NODES  = bspw_pkg::MAX_NODES_DEF,
  parameter int MAX_PLANES = bspw_pkg::MAX_PLANES_DEF,
  localparam int NODE_AW  = $clog2(MAX_NODES),
  localparam int PLANE_AW = $clog2(MAX_PLANES)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  bspw_in_if.sink                                   in_ch,
  bspw_out_if.source                                out_ch,
  input  logic        [bspw_pkg::CFG_W-1:0]        first_node,
  input  logic        [bspw_pkg::CFG_W-1:0]        last_node,
  output logic                                      node_we,
  output logic        [NODE_AW-1:0]                node_waddr,
  output logic        [bspw_pkg::NODE_DATA_W-1:0]  node_wdata,
  output logic        [NODE_AW-1:0]                node_raddr,
  input  logic        [bspw_pkg::NODE_DATA_W-1:0]  node_rdata,
  output logic                                      plane_we,
  output logic        [PLANE_AW-1:0]               plane_waddr,
  output logic        [bspw_pkg::PLANE_DATA_W-1:0] plane_wdata,
  output logic        [PLANE_AW-1:0]               plane_raddr,
  output logic                                      dist_start,
  output logic signed [bspw_pkg::COORD_W-1:0]      pt_x,
  output logic signed [bspw_pkg::COORD_W-1:0]      pt_y,
  output logic signed [bspw_pkg::COORD_W-1:0]      pt_z,
  input  bspw_pkg::dist_status_t                    dist_st
);

  localparam int STEP_W = $clog2(MAX_NODES + 1);

  bspw_pkg::walk_state_t state, state_next;

  logic                                  in_acc;
  logic                                  in_ready;
  logic                                  is_query;
  logic        [bspw_pkg::CHILD_W-1:0]  node;
  logic        [STEP_W-1:0]              steps;
  logic        [bspw_pkg::CHILD_W-1:0]  front_q, back_q;
  logic        [bspw_pkg::CHILD_W-1:0]  res_contents;
  logic                                  res_bad;
  logic                                  out_valid;
  logic        [bspw_pkg::CHILD_W-1:0]  out_contents;
  logic                                  out_bad;
  logic                                  out_free;
  logic                                  leaf, node_bad, plane_bad;
  logic        [bspw_pkg::PLANE_REF_W-1:0] rd_plane;
  logic        [bspw_pkg::CHILD_W-1:0]  rd_front, rd_back;
  logic                                  fin_leaf, fin_bad, step, out_load;

  // Input handshake and table writes straight from the item.
  assign in_acc   = in_ch.valid && in_ready;
  assign is_query = in_ch.operation == bspw_pkg::OP_QUERY;

  assign node_we     = in_acc && (in_ch.operation == bspw_pkg::OP_NODE_WR) &&
                       (32'(in_ch.index) < 32'(MAX_NODES));
  assign node_waddr  = NODE_AW'(in_ch.index);
  assign node_wdata  = {in_ch.plane_ref, in_ch.child_front, in_ch.child_back};
  assign plane_we    = in_acc && (in_ch.operation == bspw_pkg::OP_PLANE_WR) &&
                       (32'(in_ch.index) < 32'(MAX_PLANES));
  assign plane_waddr = PLANE_AW'(in_ch.index);
  assign plane_wdata = {in_ch.plane_kind, in_ch.coord_x, in_ch.coord_y, in_ch.coord_z,
                        in_ch.plane_offset};

  // Node word fields, valid in the cycle after the node read.
  assign rd_plane = node_rdata[bspw_pkg::NODE_DATA_W-1 -: bspw_pkg::PLANE_REF_W];
  assign rd_front = node_rdata[2*bspw_pkg::CHILD_W-1 -: bspw_pkg::CHILD_W];
  assign rd_back  = node_rdata[bspw_pkg::CHILD_W-1:0];

  // Reads are issued every cycle; only the walk states use the data.
  assign node_raddr  = NODE_AW'(node);
  assign plane_raddr = PLANE_AW'(rd_plane);

  // Checks on the current node number and its plane number.
  assign leaf      = node[bspw_pkg::CHILD_W-1];
  assign node_bad  = (steps >= STEP_W'(MAX_NODES)) ||
                     (node < bspw_pkg::CHILD_W'(first_node)) ||
                     (node > bspw_pkg::CHILD_W'(last_node)) ||
                     (node >= bspw_pkg::CHILD_W'(MAX_NODES));
  assign plane_bad = 32'(rd_plane) >= 32'(MAX_PLANES);

  assign out_free = !out_valid || out_ch.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bspw_pkg::WS_IDLE: begin
        if (in_acc && is_query) begin
          state_next = bspw_pkg::WS_CHECK;
        end
      end
      bspw_pkg::WS_CHECK: begin
        if (leaf || node_bad) begin
          state_next = bspw_pkg::WS_DONE;
        end else begin
          state_next = bspw_pkg::WS_PLANE;
        end
      end
      bspw_pkg::WS_PLANE: begin
        if (plane_bad) begin
          state_next = bspw_pkg::WS_DONE;
        end else begin
          state_next = bspw_pkg::WS_DIST;
        end
      end
      bspw_pkg::WS_DIST: state_next = bspw_pkg::WS_WAIT;
      bspw_pkg::WS_WAIT: begin
        if (dist_st.done) begin
          state_next = bspw_pkg::WS_CHECK;
        end
      end
      bspw_pkg::WS_DONE: begin
        if (out_free) begin
          state_next = bspw_pkg::WS_IDLE;
        end
      end
      default: state_next = bspw_pkg::WS_IDLE;
    endcase
  end

  // State outputs and strobes.
  always_comb begin
    in_ready   = (state == bspw_pkg::WS_IDLE);
    dist_start = (state == bspw_pkg::WS_DIST);
    fin_leaf   = (state == bspw_pkg::WS_CHECK) && leaf;
    fin_bad    = ((state == bspw_pkg::WS_CHECK) && !leaf && node_bad) ||
                 ((state == bspw_pkg::WS_PLANE) && plane_bad);
    step       = (state == bspw_pkg::WS_WAIT) && dist_st.done;
    out_load   = (state == bspw_pkg::WS_DONE) && out_free;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bspw_pkg::WS_IDLE;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && is_query) begin
        steps <= '0;
      end else if (step) begin
        steps <= steps + STEP_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath: point, current node, latched children, result.
  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      pt_x <= in_ch.coord_x;
      pt_y <= in_ch.coord_y;
      pt_z <= in_ch.coord_z;
      node <= bspw_pkg::CHILD_W'(in_ch.index);
    end else if (step) begin
      node <= dist_st.neg ? back_q : front_q;
    end
    if (state == bspw_pkg::WS_PLANE) begin
      front_q <= rd_front;
      back_q  <= rd_back;
    end
    if (fin_leaf) begin
      res_contents <= node;
      res_bad      <= 1'b0;
    end else if (fin_bad) begin
      res_contents <= bspw_pkg::SOLID_CODE;
      res_bad      <= 1'b1;
    end
    if (out_load) begin
      out_contents <= res_contents;
      out_bad      <= res_bad;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.contents = out_contents;
  assign out_ch.bad_node = out_bad;

  // A bad walk always reports solid.
  `BSPW_ASSERT_NOW(a_bad_is_solid, out_valid && out_bad, out_contents == bspw_pkg::SOLID_CODE, "bad walk must report solid contents")
  // Every delivered contents code is negative.
  `BSPW_ASSERT_NOW(a_contents_neg, out_valid, out_contents[bspw_pkg::CHILD_W-1], "contents code must be negative")
  // The distance unit answers only while the walk waits for it.
  `BSPW_ASSERT_NOW(a_done_in_wait, dist_st.done, state == bspw_pkg::WS_WAIT, "distance result outside wait state")
  // The step count never runs past the node table size.
  `BSPW_ASSERT_NOW(a_step_bound, 1'b1, steps <= STEP_W'(MAX_NODES), "walk step count exceeds bound")

endmodule

// ===== design/bsp_point_contents_walk.sv =====
// Point-contents walk over a clip-node tree held in two on-chip memories. Operation 0
// writes a clip node and operation 1 writes a plane; each gives no result. Operation 2
// walks the tree from the given start node with the given point and returns one result:
// the negative contents code of the leaf reached, or solid (-2) with bad_node set when a
// node lies outside first_node..last_node or past the node table, a plane number lies
// past the plane table, or the walk visits more nodes than the table holds. One item is
// in work at a time. Each node visited takes a node read, a plane read, then a compare for
// an axial plane or three passes through a single 32x32 multiplier and a final sum for a
// general plane; the walk then finishes into the output register. A finished result
// waits there while the next item is accepted. The user must write first_node and
// last_node through the configuration port only while no query is running; the block
// does not enforce it. The tables hold no defined contents after reset.
module bsp_point_contents_walk #(
  parameter int MAX_NODES  = bspw_pkg::MAX_NODES_DEF,
  parameter int MAX_PLANES = bspw_pkg::MAX_PLANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  bspw_in_if.sink                           in_ch,
  bspw_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bspw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bspw_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int NODE_AW  = $clog2(MAX_NODES);
  localparam int PLANE_AW = $clog2(MAX_PLANES);

  logic        [bspw_pkg::CFG_W-1:0]        first_node, last_node;
  logic                                      node_we, plane_we;
  logic        [NODE_AW-1:0]                node_waddr, node_raddr;
  logic        [PLANE_AW-1:0]               plane_waddr, plane_raddr;
  logic        [bspw_pkg::NODE_DATA_W-1:0]  node_wdata, node_rdata;
  logic        [bspw_pkg::PLANE_DATA_W-1:0] plane_wdata, plane_rdata;
  logic                                      dist_start;
  logic signed [bspw_pkg::COORD_W-1:0]      pt_x, pt_y, pt_z;
  logic        [bspw_pkg::KIND_W-1:0]       pl_kind;
  logic signed [bspw_pkg::COORD_W-1:0]      pl_nx, pl_ny, pl_nz, pl_dist;
  bspw_pkg::dist_status_t                    dist_st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_node <= bspw_pkg::FIRST_NODE_RST;
      last_node  <= bspw_pkg::LAST_NODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bspw_pkg::CFG_FIRST_NODE: first_node <= cfg_wdata;
        bspw_pkg::CFG_LAST_NODE:  last_node  <= cfg_wdata;
      endcase
    end
  end

  // Clip node table: plane number and both children per entry.
  bspw_ram #(
    .WIDTH (bspw_pkg::NODE_DATA_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Plane table: kind, normal and distance per entry.
  bspw_ram #(
    .WIDTH (bspw_pkg::PLANE_DATA_W),
    .DEPTH (MAX_PLANES)
  ) u_plane_ram (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (plane_wdata),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

  // Unpack the plane word for the distance unit.
  assign pl_kind = plane_rdata[bspw_pkg::PLANE_DATA_W-1 -: bspw_pkg::KIND_W];
  assign pl_nx   = plane_rdata[4*bspw_pkg::COORD_W-1 -: bspw_pkg::COORD_W];
  assign pl_ny   = plane_rdata[3*bspw_pkg::COORD_W-1 -: bspw_pkg::COORD_W];
  assign pl_nz   = plane_rdata[2*bspw_pkg::COORD_W-1 -: bspw_pkg::COORD_W];
  assign pl_dist = plane_rdata[bspw_pkg::COORD_W-1:0];

  // Walk sequencer.
  bspw_walk_ctl #(
    .MAX_NODES  (MAX_NODES),
    .MAX_PLANES (MAX_PLANES)
  ) u_walk_ctl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .first_node  (first_node),
    .last_node   (last_node),
    .node_we     (node_we),
    .node_waddr  (node_waddr),
    .node_wdata  (node_wdata),
    .node_raddr  (node_raddr),
    .node_rdata  (node_rdata),
    .plane_we    (plane_we),
    .plane_waddr (plane_waddr),
    .plane_wdata (plane_wdata),
    .plane_raddr (plane_raddr),
    .dist_start  (dist_start),
    .pt_x        (pt_x),
    .pt_y        (pt_y),
    .pt_z        (pt_z),
    .dist_st     (dist_st)
  );

  // Plane side test.
  bspw_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .start  (dist_start),
    .kind   (pl_kind),
    .norm_x (pl_nx),
    .norm_y (pl_ny),
    .norm_z (pl_nz),
    .offset (pl_dist),
    .pt_x   (pt_x),
    .pt_y   (pt_y),
    .pt_z   (pt_z),
    .status (dist_st)
  );

endmodule
